// ===== rtl/pdc_pkg.sv =====
package pdc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 15;
    localparam int FRAC_W     = 8;
    localparam int ERR_W      = SAMPLE_W + 1;
    localparam int DIFF1_W    = ERR_W + 1;
    localparam int DIFF2_W    = ERR_W + 2;
    localparam int PROD_W     = GAIN_W + DIFF2_W;
    localparam int ACC_W      = 25;
    localparam int SUM_W      = PROD_W + 3;
    localparam int DRIVE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 2 * SAMPLE_W;
    localparam int OUT_USER_W = 2;

    localparam logic [LIM_W-1:0] LIMIT_RESET = {LIM_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE           = 3'd0,
        REG_GAIN_P         = 3'd1,
        REG_GAIN_I         = 3'd2,
        REG_GAIN_D         = 3'd3,
        REG_OUTPUT_LIMIT   = 3'd4,
        REG_INTEGRAL_LIMIT = 3'd5
    } pdc_cfg_idx_t;

    typedef struct packed {
        logic                     clear;
        logic signed [PROD_W-1:0] p;
        logic signed [PROD_W-1:0] i;
        logic signed [PROD_W-1:0] d;
    } pdc_prod_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      drive_clamped;
        logic                      integral_clamped;
    } pdc_result_t;

endpackage

// ===== rtl/pdc_update.sv =====
module pdc_update
    import pdc_pkg::*;
(
    input  logic                    incremental_mode,
    input  logic [LIM_W-1:0]        output_limit,
    input  logic [LIM_W-1:0]        integral_limit,
    input  pdc_prod_t               prod,
    input  logic signed [ACC_W-1:0] integral_acc,
    input  logic signed [ACC_W-1:0] output_acc,
    output logic signed [ACC_W-1:0] integral_next,
    output logic signed [ACC_W-1:0] output_next,
    output pdc_result_t             result
);

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic                    hit;
    } clamp_t;

    function automatic clamp_t clamp_sum(input logic signed [SUM_W-1:0] x,
                                         input logic [LIM_W-1:0] lim);
        logic signed [SUM_W-1:0] bound;
        clamp_t                  r;
        bound = $signed({{(SUM_W - LIM_W - FRAC_W){1'b0}}, lim, {FRAC_W{1'b0}}});
        r.hit = 1'b1;
        if (x < -bound)
        begin
            r.value = ACC_W'(-bound);
        end
        else if (x > bound)
        begin
            r.value = ACC_W'(bound);
        end
        else
        begin
            r.value = ACC_W'(x);
            r.hit   = 1'b0;
        end
        return r;
    endfunction

    logic signed [SUM_W-1:0] i_sum;
    logic signed [SUM_W-1:0] o_sum;
    clamp_t                  i_clamp;
    clamp_t                  o_clamp;

    always_comb
    begin
        i_sum   = SUM_W'(integral_acc) + SUM_W'(prod.i);
        i_clamp = clamp_sum(i_sum, integral_limit);
        if (incremental_mode)
        begin
            o_sum = SUM_W'(output_acc) + SUM_W'(prod.p) + SUM_W'(prod.i) + SUM_W'(prod.d);
        end
        else
        begin
            o_sum = SUM_W'(prod.p) + SUM_W'(i_clamp.value) + SUM_W'(prod.d);
        end
        o_clamp = clamp_sum(o_sum, output_limit);

        if (prod.clear)
        begin
            integral_next           = '0;
            output_next             = '0;
            result.drive            = '0;
            result.drive_clamped    = 1'b0;
            result.integral_clamped = 1'b0;
        end
        else
        begin
            integral_next           = i_clamp.value;
            output_next             = o_clamp.value;
            // The clamped value always fits, so the integer bits are the floor.
            result.drive            = o_clamp.value[FRAC_W +: DRIVE_W];
            result.drive_clamped    = o_clamp.hit;
            result.integral_clamped = i_clamp.hit;
        end
    end

endmodule

// ===== rtl/pid_position_delta_controller.sv =====
// PID controller with a positional and an incremental form. Each input word carries a
// measured sample and a target; each accepted word gives exactly one result word with the
// clamped drive and two clamp flags. The block is a three-stage pipeline (input register,
// product register, result register), and a new word can be accepted every cycle while the
// output is not stalled. That rate is set by the accumulator update in the last stage, which
// adds the products to the integral and output accumulators and clamps them combinationally.
// Configuration writes take effect at once and must be made while the pipeline is empty.
module pid_position_delta_controller
    import pdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // measured [15:0], target [31:16]
    input  logic                  s_tuser,   // clear

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DRIVE_W-1:0]    m_tdata,   // drive [15:0]
    output logic [OUT_USER_W-1:0] m_tuser    // drive_clamped [0], integral_clamped [1]
);

    logic                       mode_reg;
    logic signed [GAIN_W-1:0]   gain_p_reg;
    logic signed [GAIN_W-1:0]   gain_i_reg;
    logic signed [GAIN_W-1:0]   gain_d_reg;
    logic [LIM_W-1:0]           output_limit_reg;
    logic [LIM_W-1:0]           integral_limit_reg;

    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] measured_reg;
    logic signed [SAMPLE_W-1:0] target_reg;
    logic                       clear_reg;

    logic                       prod_valid_reg;
    pdc_prod_t                  prod_reg;
    pdc_prod_t                  prod_next;

    logic                       out_valid_reg;
    pdc_result_t                result_reg;
    pdc_result_t                result_next;

    logic signed [ERR_W-1:0]    error_last_reg;
    logic signed [ERR_W-1:0]    error_before_last_reg;
    logic signed [ERR_W-1:0]    error_last_next;
    logic signed [ERR_W-1:0]    error_before_last_next;
    logic signed [ACC_W-1:0]    integral_acc_reg;
    logic signed [ACC_W-1:0]    output_acc_reg;
    logic signed [ACC_W-1:0]    integral_acc_next;
    logic signed [ACC_W-1:0]    output_acc_next;

    logic signed [ERR_W-1:0]    e0;
    logic signed [DIFF1_W-1:0]  diff1;
    logic signed [DIFF2_W-1:0]  diff2;
    logic signed [DIFF1_W-1:0]  p_operand;
    logic signed [DIFF2_W-1:0]  d_operand;

    logic                       out_ready;
    logic                       prod_ready;
    logic                       in_ready;
    logic                       in_move;
    logic                       prod_move;

    assign out_ready  = !out_valid_reg || m_tready;
    assign prod_ready = !prod_valid_reg || out_ready;
    assign in_ready   = !in_valid_reg || prod_ready;
    assign in_move    = in_valid_reg && prod_ready;
    assign prod_move  = prod_valid_reg && out_ready;

    assign s_tready   = in_ready;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = result_reg.drive;
    assign m_tuser    = {result_reg.integral_clamped, result_reg.drive_clamped};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= 1'b0;
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
            output_limit_reg   <= LIMIT_RESET;
            integral_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:           mode_reg           <= cfg_wdata[0];
                REG_GAIN_P:         gain_p_reg         <= $signed(cfg_wdata[GAIN_W-1:0]);
                REG_GAIN_I:         gain_i_reg         <= $signed(cfg_wdata[GAIN_W-1:0]);
                REG_GAIN_D:         gain_d_reg         <= $signed(cfg_wdata[GAIN_W-1:0]);
                REG_OUTPUT_LIMIT:   output_limit_reg   <= cfg_wdata[LIM_W-1:0];
                REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_wdata[LIM_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        e0        = ERR_W'(target_reg) - ERR_W'(measured_reg);
        diff1     = DIFF1_W'(e0) - DIFF1_W'(error_last_reg);
        diff2     = DIFF2_W'(e0) - (DIFF2_W'(error_last_reg) <<< 1)
                  + DIFF2_W'(error_before_last_reg);
        p_operand = mode_reg ? diff1 : DIFF1_W'(e0);
        d_operand = mode_reg ? diff2 : DIFF2_W'(diff1);

        prod_next.clear = clear_reg;
        prod_next.p     = PROD_W'(gain_p_reg) * PROD_W'(p_operand);
        prod_next.i     = PROD_W'(gain_i_reg) * PROD_W'(e0);
        prod_next.d     = PROD_W'(gain_d_reg) * PROD_W'(d_operand);

        error_last_next        = clear_reg ? '0 : e0;
        error_before_last_next = clear_reg ? '0 : error_last_reg;
    end

    pdc_update u_update (
        .incremental_mode (mode_reg),
        .output_limit     (output_limit_reg),
        .integral_limit   (integral_limit_reg),
        .prod             (prod_reg),
        .integral_acc     (integral_acc_reg),
        .output_acc       (output_acc_reg),
        .integral_next    (integral_acc_next),
        .output_next      (output_acc_next),
        .result           (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            prod_valid_reg        <= 1'b0;
            out_valid_reg         <= 1'b0;
            error_last_reg        <= '0;
            error_before_last_reg <= '0;
            integral_acc_reg      <= '0;
            output_acc_reg        <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (prod_ready)
            begin
                prod_valid_reg <= in_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= prod_valid_reg;
            end
            if (in_move)
            begin
                error_last_reg        <= error_last_next;
                error_before_last_reg <= error_before_last_next;
            end
            if (prod_move)
            begin
                integral_acc_reg <= integral_acc_next;
                output_acc_reg   <= output_acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && in_ready)
        begin
            measured_reg <= $signed(s_tdata[SAMPLE_W-1:0]);
            target_reg   <= $signed(s_tdata[IN_DATA_W-1:SAMPLE_W]);
            clear_reg    <= s_tuser;
        end
        if (in_move)
        begin
            prod_reg <= prod_next;
        end
        if (prod_move)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== test/pdc_checker.sv =====
module pdc_checker
    import pdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [DRIVE_W-1:0]    m_tdata,
    input  logic [OUT_USER_W-1:0] m_tuser,
    output int                    mismatches,
    output int                    outstanding,
    output int                    results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic        incr_mode;
    longint      kp;
    longint      ki;
    longint      kd;
    longint      drive_lim;
    longint      integ_lim;

    longint      err_prev;
    longint      err_prev2;
    longint      integ_acc;
    longint      drive_acc;

    pdc_result_t drive_q[$];

    function automatic longint hold_within(input longint x, input longint lim,
                                           output logic hit);
        hit = 1'b0;
        if (x < -lim)
        begin
            hit = 1'b1;
            return -lim;
        end
        if (x > lim)
        begin
            hit = 1'b1;
            return lim;
        end
        return x;
    endfunction

    // Advances the controller state by one word and returns the drive it produces.
    function automatic pdc_result_t advance_controller(input logic signed [SAMPLE_W-1:0] meas,
                                                       input logic signed [SAMPLE_W-1:0] tgt,
                                                       input logic clr);
        pdc_result_t r;
        longint      e0;
        longint      e1;
        longint      e2;
        longint      delta;
        longint      sum;
        longint      drv;
        logic        hit_i;
        logic        hit_d;

        r = '0;
        if (clr)
        begin
            err_prev  = 0;
            err_prev2 = 0;
            integ_acc = 0;
            drive_acc = 0;
            return r;
        end

        e0 = longint'(tgt) - longint'(meas);
        e1 = err_prev;
        e2 = err_prev2;
        err_prev2 = e1;
        err_prev  = e0;

        integ_acc = hold_within(integ_acc + ki * e0, integ_lim <<< FRAC_W, hit_i);

        if (incr_mode)
        begin
            delta = kp * (e0 - e1) + ki * e0 + kd * (e0 - 2 * e1 + e2);
            drive_acc = hold_within(drive_acc + delta, drive_lim <<< FRAC_W, hit_d);
        end
        else
        begin
            sum = kp * e0 + integ_acc + kd * (e0 - e1);
            drive_acc = hold_within(sum, drive_lim <<< FRAC_W, hit_d);
        end

        drv = drive_acc >>> FRAC_W;
        r.drive            = drv[DRIVE_W-1:0];
        r.drive_clamped    = hit_d;
        r.integral_clamped = hit_i;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pdc_result_t got;
        pdc_result_t want;

        if (!rst_n)
        begin
            incr_mode       = 1'b0;
            kp              = 0;
            ki              = 0;
            kd              = 0;
            drive_lim       = longint'(LIMIT_RESET);
            integ_lim       = longint'(LIMIT_RESET);
            err_prev        = 0;
            err_prev2       = 0;
            integ_acc       = 0;
            drive_acc       = 0;
            drive_q.delete();
            mismatches      <= 0;
            outstanding     <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODE:           incr_mode = cfg_wdata[0];
                    REG_GAIN_P:         kp = longint'($signed(cfg_wdata));
                    REG_GAIN_I:         ki = longint'($signed(cfg_wdata));
                    REG_GAIN_D:         kd = longint'($signed(cfg_wdata));
                    REG_OUTPUT_LIMIT:   drive_lim = longint'(cfg_wdata[LIM_W-1:0]);
                    REG_INTEGRAL_LIMIT: integ_lim = longint'(cfg_wdata[LIM_W-1:0]);
                    default:            ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                drive_q.push_back(advance_controller(s_tdata[SAMPLE_W-1:0],
                                                     s_tdata[IN_DATA_W-1:SAMPLE_W],
                                                     s_tuser));
            end

            if (m_tvalid && m_tready)
            begin
                got.drive            = m_tdata;
                got.drive_clamped    = m_tuser[0];
                got.integral_clamped = m_tuser[1];
                results_checked <= results_checked + 1;
                if (drive_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("pdc_checker: unexpected word at %0t: drive %0d", $time,
                                 $signed(got.drive));
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (got.drive != want.drive
                        || got.drive_clamped != want.drive_clamped
                        || got.integral_clamped != want.integral_clamped)
                    begin
                        if (mismatches < 10)
                            $display("pdc_checker: mismatch at %0t: drive exp %0d got %0d,",
                                     $time, $signed(want.drive), $signed(got.drive),
                                     " drive_clamped exp %b got %b,",
                                     want.drive_clamped, got.drive_clamped,
                                     " integral_clamped exp %b got %b",
                                     want.integral_clamped, got.integral_clamped);
                        mismatches <= mismatches + 1;
                    end
                end
            end

            outstanding <= drive_q.size();
        end
    end

endmodule

// ===== test/tb_pid_position_delta_controller.sv =====
module tb_pid_position_delta_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import pdc_pkg::*;

    localparam int RAND_PHASES     = 20;
    localparam int WORDS_PER_PHASE = 100;
    localparam int HOLD_CYCLES     = 300;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DRIVE_W-1:0]    m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    int mismatches;
    int outstanding;
    int results_checked;

    bit quiet    = 1'b0;
    bit hold_req = 1'b0;
    int words_sent;
    int clears_sent;
    int pos_settings;
    int incr_settings;

    pid_position_delta_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    pdc_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("tb_pid_position_delta_controller: done, errors");
        $finish;
    end

    // The drive side stalls in random bursts, holds off for a long stretch on request,
    // and stays ready once the run goes quiet.
    initial
    begin
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (quiet)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(1) == 1)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(40, 1)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(19, 1)) @(posedge clk);
            end
        end
    end

    task automatic write_reg(input pdc_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic mode, input logic [GAIN_W-1:0] gp,
                                input logic [GAIN_W-1:0] gi, input logic [GAIN_W-1:0] gd,
                                input logic [LIM_W-1:0] ol, input logic [LIM_W-1:0] il);
        write_reg(REG_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_OUTPUT_LIMIT, {1'b0, ol});
        write_reg(REG_INTEGRAL_LIMIT, {1'b0, il});
        cfg_we <= 1'b0;
        if (mode)
            incr_settings++;
        else
            pos_settings++;
    endtask

    task automatic send_word(input logic [SAMPLE_W-1:0] meas, input logic [SAMPLE_W-1:0] tgt,
                             input logic clr, input int gap_pct);
        s_tvalid <= 1'b1;
        s_tdata  <= {tgt, meas};
        s_tuser  <= clr;
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
        if (clr)
            clears_sent++;
        if (!quiet && $urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(19, 1)) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        int v;

        case ($urandom_range(4))
            0: return GAIN_W'($urandom);
            1: return 16'h8000;
            2: return 16'h7FFF;
            default:
            begin
                v = int'($urandom_range(1024)) - 512;
                return v[GAIN_W-1:0];
            end
        endcase
    endfunction

    function automatic logic [LIM_W-1:0] pick_limit();
        case ($urandom_range(3))
            0: return '0;
            1: return LIMIT_RESET;
            2: return LIM_W'($urandom_range(32767));
            default: return LIM_W'($urandom_range(2000));
        endcase
    endfunction

    // Mostly a measured value that tracks the target closely, sometimes anything at all.
    function automatic void pick_samples(output logic [SAMPLE_W-1:0] meas,
                                         output logic [SAMPLE_W-1:0] tgt);
        int t;
        int m;

        t = int'($urandom_range(65535)) - 32768;
        if ($urandom_range(3) == 0)
            m = int'($urandom_range(65535)) - 32768;
        else
        begin
            m = t + int'($urandom_range(600)) - 300;
            if (m > 32767 || m < -32768)
                m = t;
        end
        meas = m[SAMPLE_W-1:0];
        tgt  = t[SAMPLE_W-1:0];
    endfunction

    initial
    begin
        logic [SAMPLE_W-1:0] meas;
        logic [SAMPLE_W-1:0] tgt;
        int                  gap;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(16'd100, -16'sd100, 1'b0, 30);
        send_word(16'h8000, 16'h7FFF, 1'b0, 30);
        drain();

        program_regs(1'b0, 16'h0100, 16'h0040, 16'h0080, 15'h7FFF, 15'h7FFF);
        send_word(16'h0000, 16'h0000, 1'b0, 30);
        send_word(16'h8000, 16'h7FFF, 1'b0, 30);
        send_word(16'h7FFF, 16'h8000, 1'b0, 30);
        send_word(16'h7FFF, 16'h7FFF, 1'b0, 30);
        send_word(16'd5, -16'sd7, 1'b0, 30);
        send_word(16'd1234, 16'h0000, 1'b1, 30);
        send_word(16'd10, 16'd20, 1'b0, 30);
        drain();

        program_regs(1'b0, 16'h8000, 16'h7FFF, 16'h8000, 15'd0, 15'd0);
        send_word(16'd0, 16'd1, 1'b0, 30);
        send_word(16'd1, 16'd0, 1'b0, 30);
        send_word(16'd0, 16'd0, 1'b0, 30);
        send_word(16'h8000, 16'h7FFF, 1'b0, 30);
        drain();

        program_regs(1'b1, 16'h7FFF, 16'h8000, 16'h7FFF, 15'h7FFF, 15'h7FFF);
        send_word(16'h8000, 16'h7FFF, 1'b0, 30);
        send_word(16'h7FFF, 16'h8000, 1'b0, 30);
        send_word(16'd0, 16'd0, 1'b0, 30);
        send_word(16'h7FFF, 16'h7FFF, 1'b0, 30);
        drain();

        program_regs(1'b1, 16'h0100, 16'h0010, 16'h0040, 15'd100, 15'd50);
        send_word(16'd0, 16'd300, 1'b0, 30);
        send_word(16'd0, 16'd300, 1'b0, 30);
        send_word(16'd0, -16'sd300, 1'b0, 30);
        send_word(16'h8000, 16'h8000, 1'b1, 30);
        send_word(16'd0, 16'd1, 1'b0, 30);
        send_word(16'd0, 16'd200, 1'b0, 30);
        drain();

        // The accumulators carry over into the positional form without a clear.
        program_regs(1'b0, 16'h0100, 16'h0010, 16'h0040, 15'd100, 15'd50);
        send_word(16'd0, 16'd3, 1'b0, 30);
        send_word(16'd0, 16'd3, 1'b0, 30);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            quiet = (ph >= RAND_PHASES - 3);
            gap = (quiet || ph % 4 == 0) ? 0 : $urandom_range(40);
            program_regs(1'($urandom_range(1)), pick_gain(), pick_gain(), pick_gain(),
                         pick_limit(), pick_limit());
            if (ph == 2)
            begin
                hold_req = 1'b1;
                gap = 0;
            end
            for (int k = 0; k < WORDS_PER_PHASE; k++)
            begin
                pick_samples(meas, tgt);
                send_word(meas, tgt, $urandom_range(39) == 0, gap);
            end
            drain();
        end

        repeat (10) @(posedge clk);

        $display("tb_pid_position_delta_controller: %0d words sent (%0d clear), %0d positional %s",
                 words_sent, clears_sent, pos_settings, "settings");
        $display("tb_pid_position_delta_controller: %0d incremental settings, %0d results checked",
                 incr_settings, results_checked);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_pid_position_delta_controller: done, clean");
        else
            $display("tb_pid_position_delta_controller: done, errors");
        $finish;
    end

endmodule

// ===== pid_position_delta_controller.f =====
rtl/pdc_pkg.sv
rtl/pdc_update.sv
rtl/pid_position_delta_controller.sv
test/pdc_checker.sv
test/tb_pid_position_delta_controller.sv
